@@ sv/sprite_move_stepper_core_assert.svh @@
`ifndef SPRITE_MOVE_STEPPER_CORE_ASSERT_SVH
`define SPRITE_MOVE_STEPPER_CORE_ASSERT_SVH

// same-cycle implication on clk, masked while rst_n is low
`define SMSTP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on clk, masked while rst_n is low
`define SMSTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/smstp_pkg.sv @@
package smstp_pkg;

    // coordinate and field widths
    localparam int COORD_W = 16;
    localparam int STEP_W  = COORD_W + 1;
    localparam int SPEED_W = 16;
    localparam int CMD_W   = 2;
    localparam int HEAD_W  = 2;
    localparam int FRAME_W = 4;
    localparam int FC_W    = 5;

    // q.8 fraction and datapath widths
    localparam int Q_BITS  = 8;
    localparam int MUL_W   = 16;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int RAD_W   = 2 * COORD_W + 2 * Q_BITS;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 1;
    localparam int SUB_W   = ROOT_W + 3;
    localparam int QUO_W   = SPEED_W;
    localparam int CNT_W   = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PLACE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // facing codes
    localparam logic [HEAD_W-1:0] FACE_DOWN  = 2'd0;
    localparam logic [HEAD_W-1:0] FACE_LEFT  = 2'd1;
    localparam logic [HEAD_W-1:0] FACE_RIGHT = 2'd2;
    localparam logic [HEAD_W-1:0] FACE_UP    = 2'd3;

    localparam logic [FC_W-1:0]    FRAME_COUNT_RESET = 5'd4;
    localparam logic [FC_W-1:0]    FC_MIN_RUN        = 5'd2;
    localparam logic [FC_W-1:0]    FRAME_MOD_MAX     = 5'd16;
    localparam logic [SPEED_W-1:0] SPEED_ONE         = 16'd256;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [COORD_W-1:0] arg_x;
        logic signed [COORD_W-1:0] arg_y;
        logic [SPEED_W-1:0]        speed;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [HEAD_W-1:0]         facing;
        logic [FRAME_W-1:0]        frame;
        logic                      moving;
        logic                      finished;
    } res_t;

    // shared compare-subtract unit
    typedef struct packed {
        logic [SUB_W-1:0] a;
        logic [SUB_W-1:0] b;
    } sub_op_t;

    typedef struct packed {
        logic             ge;
        logic [SUB_W-1:0] diff;
    } sub_res_t;

endpackage

@@ sv/smstp_mul.sv @@
module smstp_mul import smstp_pkg::*; (
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic [PROD_W-1:0] p
);

    // unsigned product, registered by the caller
    assign p = PROD_W'(a) * PROD_W'(b);

endmodule

@@ sv/smstp_subu.sv @@
module smstp_subu import smstp_pkg::*; (
    input  sub_op_t  op,
    output sub_res_t res
);

    logic [SUB_W:0] d;

    // borrow out tells a < b
    assign d        = {1'b0, op.a} - {1'b0, op.b};
    assign res.ge   = ~d[SUB_W];
    assign res.diff = d[SUB_W-1:0];

endmodule

@@ sv/sprite_move_stepper_core.sv @@
// sprite move stepper: takes place, move and tick commands, one transaction at a time, and
// returns one result transaction per command with position, facing, animation frame, a
// moving flag and a finished pulse. place, move, idle ticks and jump ticks (speed below
// 1.0) go straight from acceptance to the final state, which loads the result register.
// a stepped tick runs one shared 16x16 multiplier and one shared 27-bit compare-subtract
// unit under a small sequencer: squaring of both axes and their sum, a bit-pair square
// root, per axis the scaled product and a 16-step restoring divide, then the position
// update and the facing choice, frame modulo by repeated subtraction (none when the move
// ends or the frame is held) and the final state that loads the result. cmd_stall stays
// high while a command is being worked; a finished result waits in the output register
// while the next command runs, and that command's final state is held for as long as the
// waiting result stays stalled.
`include "sprite_move_stepper_core_assert.svh"

module sprite_move_stepper_core import smstp_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [FC_W-1:0] cfg_wr_data,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  cmd_t            cmd_data,
    output logic            res_valid,
    input  logic            res_stall,
    output res_t            res_data
);

    // sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQX   = 4'd1;
    localparam logic [3:0] ST_SQY   = 4'd2;
    localparam logic [3:0] ST_SQSUM = 4'd3;
    localparam logic [3:0] ST_SQRT  = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_DINIT = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_STEP  = 4'd8;
    localparam logic [3:0] ST_UPD   = 4'd9;
    localparam logic [3:0] ST_HEAD  = 4'd10;
    localparam logic [3:0] ST_FMOD  = 4'd11;
    localparam logic [3:0] ST_FIN   = 4'd12;

    localparam int RND_W = QUO_W + 1;
    localparam int SMAG_W = RND_W - Q_BITS;

    localparam logic [CNT_W-1:0]        SQRT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0]        DIV_LAST  = CNT_W'(QUO_W - 1);
    localparam logic [RND_W-1:0]        HALF_UP   = RND_W'(128);
    localparam logic [RND_W-1:0]        HALF_DN   = RND_W'(127);
    localparam logic [ROOT_W-1:0]       ROOT_MIN  = ROOT_W'(256);
    localparam logic signed [STEP_W-1:0] STEP_LIM = STEP_W'(256);
    localparam logic signed [COORD_W+1:0] SAT_HI  = {3'b000, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W+1:0] SAT_LO  = {3'b111, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] rem;
        logic signed [COORD_W-1:0] pos;
    } adv_t;

    // clamp a widened sum back to coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [COORD_W+1:0] v
    );
        logic signed [COORD_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[COORD_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[COORD_W-1:0];
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // move one axis by inc, or snap to the target when inc would reach it
    function automatic adv_t advance(
        input logic signed [COORD_W-1:0] rem,
        input logic signed [COORD_W-1:0] pos,
        input logic signed [STEP_W-1:0]  inc
    );
        logic [STEP_W-1:0]         mag_inc;
        logic [STEP_W-1:0]         mag_rem;
        logic signed [COORD_W+1:0] rem_w;
        logic signed [COORD_W+1:0] pos_w;
        logic signed [COORD_W+1:0] inc_w;
        adv_t                      r;
        rem_w   = {{2{rem[COORD_W-1]}}, rem};
        pos_w   = {{2{pos[COORD_W-1]}}, pos};
        inc_w   = {inc[STEP_W-1], inc};
        mag_inc = inc[STEP_W-1] ? STEP_W'(-inc) : STEP_W'(inc);
        mag_rem = rem[COORD_W-1] ? STEP_W'(-rem_w) : STEP_W'(rem_w);
        if (mag_inc < mag_rem)
        begin
            r.rem = sat_coord(rem_w - inc_w);
            r.pos = sat_coord(pos_w + inc_w);
        end
        else
        begin
            r.rem = '0;
            r.pos = sat_coord(pos_w + rem_w);
        end
        return r;
    endfunction

    logic [3:0]                state_reg,  state_next;
    logic signed [COORD_W-1:0] pos_x_reg,  pos_x_next;
    logic signed [COORD_W-1:0] pos_y_reg,  pos_y_next;
    logic signed [COORD_W-1:0] rem_x_reg,  rem_x_next;
    logic signed [COORD_W-1:0] rem_y_reg,  rem_y_next;
    logic [SPEED_W-1:0]        speed_reg,  speed_next;
    logic [HEAD_W-1:0]         head_reg,   head_next;
    logic [FRAME_W-1:0]        frame_reg,  frame_next;
    logic [FC_W-1:0]           fc_reg,     fc_next;
    logic                      done_reg,   done_next;
    logic                      axis_reg,   axis_next;
    logic [CNT_W-1:0]          cnt_reg,    cnt_next;
    logic                      res_valid_reg, res_valid_next;
    res_t                      res_reg,    res_next;

    // datapath registers, no reset needed
    logic [PROD_W-1:0]         prod_reg,   prod_next;
    logic [PROD_W-1:0]         acc_reg,    acc_next;
    logic [RAD_W-1:0]          work_reg,   work_next;
    logic [REM_W-1:0]          srem_reg,   srem_next;
    logic [ROOT_W-1:0]         root_reg,   root_next;
    logic [QUO_W-1:0]          quo_reg,    quo_next;
    logic signed [STEP_W-1:0]  step_x_reg, step_x_next;
    logic signed [STEP_W-1:0]  step_y_reg, step_y_next;
    logic [FC_W-1:0]           fval_reg,   fval_next;

    logic [COORD_W-1:0]        mag_x;
    logic [COORD_W-1:0]        mag_y;
    logic [MUL_W-1:0]          mul_a;
    logic [MUL_W-1:0]          mul_b;
    logic [PROD_W-1:0]         mul_p;
    sub_op_t                   sub_op;
    sub_res_t                  sub_res;
    logic [PROD_W-1:0]         sq_sum;
    logic [FC_W-1:0]           fc_m1;
    logic [FC_W-1:0]           frame_mod;
    logic [RND_W-1:0]          rnd_up;
    logic [RND_W-1:0]          rnd_dn;
    logic signed [STEP_W-1:0]  step_val;
    logic                      axis_neg;
    adv_t                      adv_x;
    adv_t                      adv_y;
    adv_t                      jmp_x;
    adv_t                      jmp_y;
    logic                      accept;

    smstp_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    smstp_subu u_subu (
        .op  (sub_op),
        .res (sub_res)
    );

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // magnitudes of the remaining distances; the most negative value maps to 2^(w-1)
    assign mag_x = rem_x_reg[COORD_W-1] ? unsigned'(-rem_x_reg) : unsigned'(rem_x_reg);
    assign mag_y = rem_y_reg[COORD_W-1] ? unsigned'(-rem_y_reg) : unsigned'(rem_y_reg);

    assign sq_sum = acc_reg + prod_reg;

    // frame wraps modulo frame_count-1, capped at 16
    assign fc_m1     = fc_reg - 1'b1;
    assign frame_mod = (fc_m1 > FRAME_MOD_MAX) ? FRAME_MOD_MAX : fc_m1;

    // round half up of m/256 in the signed sense, so a negative axis rounds its magnitude half down
    assign axis_neg = axis_reg ? rem_y_reg[COORD_W-1] : rem_x_reg[COORD_W-1];
    assign rnd_up   = {1'b0, quo_reg} + HALF_UP;
    assign rnd_dn   = {1'b0, quo_reg} + HALF_DN;
    assign step_val = axis_neg
                      ? -$signed({{(STEP_W-SMAG_W){1'b0}}, rnd_dn[RND_W-1:Q_BITS]})
                      : $signed({{(STEP_W-SMAG_W){1'b0}}, rnd_up[RND_W-1:Q_BITS]});

    // stepped and jump axis updates
    assign adv_x = advance(rem_x_reg, pos_x_reg, step_x_reg);
    assign adv_y = advance(rem_y_reg, pos_y_reg, step_y_reg);
    assign jmp_x = advance(rem_x_reg, pos_x_reg, {rem_x_reg[COORD_W-1], rem_x_reg});
    assign jmp_y = advance(rem_y_reg, pos_y_reg, {rem_y_reg[COORD_W-1], rem_y_reg});

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQX:
            begin
                mul_a = MUL_W'(mag_x);
                mul_b = MUL_W'(mag_x);
            end
            ST_SQY:
            begin
                mul_a = MUL_W'(mag_y);
                mul_b = MUL_W'(mag_y);
            end
            ST_MUL:
            begin
                mul_a = MUL_W'(speed_reg);
                mul_b = axis_reg ? MUL_W'(mag_y) : MUL_W'(mag_x);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared compare-subtract operands
    always_comb
    begin
        sub_op = '0;
        unique case (state_reg)
            // bit-pair square root: bring down two radicand bits, trial 4*root+1
            ST_SQRT:
            begin
                sub_op.a = {srem_reg, work_reg[RAD_W-1 -: 2]};
                sub_op.b = {1'b0, root_reg, 2'b01};
            end
            // restoring divide by the root
            ST_DIV:
            begin
                sub_op.a = {2'b00, srem_reg[ROOT_W-1:0], work_reg[RAD_W-1]};
                sub_op.b = {3'b000, root_reg};
            end
            // frame modulo by repeated subtraction
            ST_FMOD:
            begin
                sub_op.a = SUB_W'(fval_reg);
                sub_op.b = SUB_W'(frame_mod);
            end
            default:
            begin
                sub_op = '0;
            end
        endcase
    end

    // sequencer and state update
    always_comb
    begin
        state_next     = state_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        rem_x_next     = rem_x_reg;
        rem_y_next     = rem_y_reg;
        speed_next     = speed_reg;
        head_next      = head_reg;
        frame_next     = frame_reg;
        fc_next        = cfg_wr_en ? cfg_wr_data : fc_reg;
        done_next      = done_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        work_next      = work_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        quo_next       = quo_reg;
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;
        fval_next      = fval_reg;
        res_next       = res_reg;
        // result register drains when taken
        res_valid_next = res_valid_reg && res_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next  = 1'b0;
                    state_next = ST_FIN;
                    unique case (cmd_data.cmd)
                        CMD_PLACE:
                        begin
                            pos_x_next = cmd_data.arg_x;
                            pos_y_next = cmd_data.arg_y;
                        end
                        CMD_MOVE:
                        begin
                            rem_x_next = cmd_data.arg_x;
                            rem_y_next = cmd_data.arg_y;
                            speed_next = cmd_data.speed;
                            done_next  = (cmd_data.arg_x == '0) && (cmd_data.arg_y == '0);
                        end
                        CMD_TICK:
                        begin
                            if ((rem_x_reg != '0) || (rem_y_reg != '0))
                            begin
                                if (speed_reg < SPEED_ONE)
                                begin
                                    // jump the whole way
                                    pos_x_next = jmp_x.pos;
                                    rem_x_next = jmp_x.rem;
                                    pos_y_next = jmp_y.pos;
                                    rem_y_next = jmp_y.rem;
                                    frame_next = '0;
                                    done_next  = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_SQX;
                                end
                            end
                        end
                        default:
                        begin
                            // unused code reports the state unchanged
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SQX:
            begin
                prod_next  = mul_p;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                acc_next   = prod_reg;
                prod_next  = mul_p;
                state_next = ST_SQSUM;
            end
            ST_SQSUM:
            begin
                // radicand is the squared norm in q.16
                work_next  = {sq_sum, {(RAD_W-PROD_W){1'b0}}};
                srem_next  = '0;
                root_next  = '0;
                cnt_next   = SQRT_LAST;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                work_next = work_reg << 2;
                if (sub_res.ge)
                begin
                    srem_next = sub_res.diff[REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = sub_op.a[REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    axis_next  = 1'b0;
                    state_next = ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                // numerator is speed*|d|*256; its top part is already below the root
                srem_next  = REM_W'(prod_reg[PROD_W-1:Q_BITS]);
                work_next  = {prod_reg[Q_BITS-1:0], {(RAD_W-Q_BITS){1'b0}}};
                quo_next   = '0;
                cnt_next   = DIV_LAST;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                work_next = work_reg << 1;
                if (sub_res.ge)
                begin
                    srem_next = sub_res.diff[REM_W-1:0];
                    quo_next  = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = sub_op.a[REM_W-1:0];
                    quo_next  = {quo_reg[QUO_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    state_next = ST_STEP;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_STEP:
            begin
                if (axis_reg)
                begin
                    step_y_next = step_val;
                    state_next  = ST_UPD;
                end
                else
                begin
                    step_x_next = step_val;
                    axis_next   = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_UPD:
            begin
                pos_x_next = adv_x.pos;
                rem_x_next = adv_x.rem;
                pos_y_next = adv_y.pos;
                rem_y_next = adv_y.rem;
                state_next = ST_HEAD;
            end
            ST_HEAD:
            begin
                if ((rem_x_reg == '0) && (rem_y_reg == '0))
                begin
                    frame_next = '0;
                    done_next  = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    // larger remaining axis picks the facing, y wins ties
                    if (mag_x > mag_y)
                    begin
                        head_next = rem_x_reg[COORD_W-1] ? FACE_LEFT : FACE_RIGHT;
                    end
                    else if (rem_y_reg != '0)
                    begin
                        head_next = rem_y_reg[COORD_W-1] ? FACE_UP : FACE_DOWN;
                    end
                    if (fc_reg < FC_MIN_RUN)
                    begin
                        frame_next = '0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        fval_next  = {1'b0, frame_reg} + 1'b1;
                        state_next = ST_FMOD;
                    end
                end
            end
            ST_FMOD:
            begin
                if (sub_res.ge)
                begin
                    fval_next = sub_res.diff[FC_W-1:0];
                end
                else
                begin
                    frame_next = fval_reg[FRAME_W-1:0];
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // load the result once the previous one is gone
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.pos_x    = pos_x_reg;
                    res_next.pos_y    = pos_y_reg;
                    res_next.facing   = head_reg;
                    res_next.frame    = frame_reg;
                    res_next.moving   = (rem_x_reg != '0) || (rem_y_reg != '0);
                    res_next.finished = done_reg;
                    res_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            rem_x_reg     <= '0;
            rem_y_reg     <= '0;
            speed_reg     <= '0;
            head_reg      <= FACE_DOWN;
            frame_reg     <= '0;
            fc_reg        <= FRAME_COUNT_RESET;
            done_reg      <= 1'b0;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            rem_x_reg     <= rem_x_next;
            rem_y_reg     <= rem_y_next;
            speed_reg     <= speed_next;
            head_reg      <= head_next;
            frame_reg     <= frame_next;
            fc_reg        <= fc_next;
            done_reg      <= done_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        work_reg   <= work_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        quo_reg    <= quo_next;
        step_x_reg <= step_x_next;
        step_y_reg <= step_y_next;
        fval_reg   <= fval_next;
        res_reg    <= res_next;
    end

    // square root remainder never exceeds twice the partial root
    `SMSTP_ASSERT_IMPL(a_sqrt_rem_bound, state_reg == ST_SQRT, (srem_reg <= {root_reg, 1'b0}), "sqrt remainder out of bound")

    // divide remainder stays below a root of at least 1.0 in q.8
    `SMSTP_ASSERT_IMPL(a_div_rem_bound, state_reg == ST_DIV, (srem_reg < {1'b0, root_reg}) && (root_reg >= ROOT_MIN), "divide remainder or root out of bound")

    // a per-axis step never exceeds the speed ceiling of 256 pixels
    `SMSTP_ASSERT_IMPL(a_step_bound, state_reg == ST_UPD, (step_x_reg <= STEP_LIM) && (step_x_reg >= -STEP_LIM) && (step_y_reg <= STEP_LIM) && (step_y_reg >= -STEP_LIM), "axis step too large")

    // frame modulo only runs with a usable modulus and leaves a frame in range
    `SMSTP_ASSERT_NEXT(a_fmod_range, (state_reg == ST_FMOD) && !sub_res.ge, (state_reg == ST_FIN) && ({1'b0, frame_reg} < frame_mod) && (frame_mod != '0), "frame modulo out of range")

endmodule

@@ test/sprite_move_stepper_core_test.sv @@
module sprite_move_stepper_core_test;
    import smstp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // the one command code that the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // generous bound, several times the slowest legal run
    localparam int CYCLE_LIMIT      = 600000;
    localparam int RESET_CYCLES     = 6;
    localparam int RANDOM_PER_PHASE = 64;
    // settle time before a config write, and drain time at the end
    localparam int IDLE_GAP         = 8;
    localparam int TAIL_CYCLES      = 100;
    localparam int MAX_REPORTS      = 40;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_wr_en = 1'b0;
    logic [FC_W-1:0] cfg_wr_data = '0;
    logic            cmd_valid = 1'b0;
    logic            cmd_stall;
    cmd_t            cmd_data = '0;
    logic            res_valid;
    logic            res_stall = 1'b0;
    res_t            res_data;

    sprite_move_stepper_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_data   (cmd_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    always #2 clk = ~clk;

    // command transactions waiting to be sent, and results predicted for sent ones
    cmd_t pending_cmds[$];
    res_t pending_results[$];

    int error_count  = 0;
    int result_count = 0;
    int cycle_count  = 0;
    int items_queued = 0;

    // predicted sprite state, reset values match the block
    longint                sprite_x    = 0;
    longint                sprite_y    = 0;
    longint                left_x      = 0;
    longint                left_y      = 0;
    logic [SPEED_W-1:0]    move_speed  = '0;
    logic [HEAD_W-1:0]     face_dir    = FACE_DOWN;
    int unsigned           anim_frame  = 0;
    int unsigned           frame_limit = FRAME_COUNT_RESET;

    // driver and monitor pacing
    int send_gap   = 0;
    bit send_burst = 1'b0;
    int wait_left  = 0;
    bit take_burst = 1'b0;

    // saturate to the signed coordinate range
    function automatic longint clamp_coord(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (COORD_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // q.8 step for one axis, rounded half up in the signed sense
    function automatic longint axis_step(longint d, longint unsigned root);
        longint unsigned dmag;
        longint unsigned scaled;
        if (d == 0)
            return 0;
        dmag   = (d < 0) ? longint'(-d) : longint'(d);
        scaled = (longint'(move_speed) * dmag * 256) / root;
        if (d > 0)
            return longint'((scaled + 128) >> 8);
        return -longint'((scaled + 127) >> 8);
    endfunction

    // move one axis by inc, snapping onto the target when it would reach or pass it
    task automatic advance_axis(inout longint left, inout longint pos, input longint inc);
        longint inc_mag;
        longint left_mag;
        inc_mag  = (inc < 0) ? -inc : inc;
        left_mag = (left < 0) ? -left : left;
        if (inc_mag < left_mag)
        begin
            left = clamp_coord(left - inc);
            pos  = clamp_coord(pos + inc);
        end
        else
        begin
            pos  = clamp_coord(pos + left);
            left = 0;
        end
    endtask

    // expected result of one command transaction, updates the predicted state
    task automatic predict_sprite_step(input cmd_t c, output res_t r);
        longint          ax;
        longint          ay;
        longint          sx;
        longint          sy;
        longint          mag_x;
        longint          mag_y;
        longint unsigned radicand;
        longint unsigned root;
        longint unsigned probe;
        int unsigned     modulus;
        bit              done;
        ax   = $signed(c.arg_x);
        ay   = $signed(c.arg_y);
        done = 1'b0;
        case (c.cmd)
            CMD_PLACE:
            begin
                sprite_x = clamp_coord(ax);
                sprite_y = clamp_coord(ay);
            end
            CMD_MOVE:
            begin
                left_x     = clamp_coord(ax);
                left_y     = clamp_coord(ay);
                move_speed = c.speed;
                done       = (left_x == 0 && left_y == 0);
            end
            CMD_TICK:
            begin
                if (left_x != 0 || left_y != 0)
                begin
                    if (move_speed < SPEED_ONE)
                    begin
                        // jump the whole way, facing untouched; the frame is cleared below as the move ends
                        advance_axis(left_x, sprite_x, left_x);
                        advance_axis(left_y, sprite_y, left_y);
                    end
                    else
                    begin
                        // floor square root of the squared norm in q.16, giving a q.8 root
                        radicand = longint'(left_x * left_x + left_y * left_y) << 16;
                        root     = 0;
                        probe    = longint'(1) << 62;
                        while (probe > radicand)
                            probe = probe >> 2;
                        while (probe != 0)
                        begin
                            if (radicand >= root + probe)
                            begin
                                radicand = radicand - (root + probe);
                                root     = (root >> 1) + probe;
                            end
                            else
                                root = root >> 1;
                            probe = probe >> 2;
                        end
                        sx = axis_step(left_x, root);
                        sy = axis_step(left_y, root);
                        advance_axis(left_x, sprite_x, sx);
                        advance_axis(left_y, sprite_y, sy);
                        // larger remaining axis picks facing, y wins ties
                        mag_x = (left_x < 0) ? -left_x : left_x;
                        mag_y = (left_y < 0) ? -left_y : left_y;
                        if (mag_x > mag_y)
                        begin
                            if (left_x < 0)
                                face_dir = FACE_LEFT;
                            else if (left_x > 0)
                                face_dir = FACE_RIGHT;
                        end
                        else
                        begin
                            if (left_y < 0)
                                face_dir = FACE_UP;
                            else if (left_y > 0)
                                face_dir = FACE_DOWN;
                        end
                        // frame wraps modulo frame_count-1, held at 0 for tiny counts
                        if (frame_limit <= 1)
                            anim_frame = 0;
                        else
                        begin
                            modulus = frame_limit - 1;
                            if (modulus > FRAME_MOD_MAX)
                                modulus = FRAME_MOD_MAX;
                            anim_frame = (anim_frame + 1) % modulus;
                        end
                    end
                    if (left_x == 0 && left_y == 0)
                    begin
                        anim_frame = 0;
                        done       = 1'b1;
                    end
                end
            end
            default:
            begin
                // unused code leaves the state alone
            end
        endcase
        r.pos_x    = sprite_x[COORD_W-1:0];
        r.pos_y    = sprite_y[COORD_W-1:0];
        r.facing   = face_dir;
        r.frame    = anim_frame[FRAME_W-1:0];
        r.moving   = (left_x != 0 || left_y != 0);
        r.finished = done;
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                                      result_count, name, got, want));
    endtask

    // queue one command transaction, ignored codes are not counted as items
    task automatic push_cmd(input logic [CMD_W-1:0] code, input int x, input int y,
                            input int spd);
        cmd_t c;
        c.cmd   = code;
        c.arg_x = x[COORD_W-1:0];
        c.arg_y = y[COORD_W-1:0];
        c.speed = spd[SPEED_W-1:0];
        pending_cmds.push_back(c);
        if (code != CMD_UNUSED)
            items_queued++;
    endtask

    // mostly place / move / tick sequences with random content, plus raw noise
    task automatic gen_random_items(input int n);
        int start;
        int kind;
        int span;
        int dx;
        int dy;
        int reach;
        int spd;
        start = items_queued;
        while (items_queued - start < n)
        begin
            if ($urandom_range(0, 3) == 0)
                push_cmd(CMD_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            else
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    if ($urandom_range(0, 3) == 0)
                        push_cmd(CMD_PLACE, $urandom, $urandom, $urandom);
                    else
                        push_cmd(CMD_PLACE, $urandom_range(0, 4000) - 2000,
                                 $urandom_range(0, 4000) - 2000, $urandom);
                end
                kind = $urandom_range(0, 9);
                span = $urandom_range(1, 300);
                dx   = $urandom_range(0, span);
                dy   = $urandom_range(0, span);
                if ($urandom_range(0, 1) == 1)
                    dx = -dx;
                if ($urandom_range(0, 1) == 1)
                    dy = -dy;
                case (kind)
                    6:
                    begin
                        // full range distances and speeds, saturation territory
                        dx  = $signed(16'($urandom));
                        dy  = $signed(16'($urandom));
                        spd = $urandom_range(256, 65535);
                    end
                    7:
                        spd = $urandom_range(0, 255);
                    9:
                    begin
                        dx  = 0;
                        dy  = 0;
                        spd = $urandom_range(0, 65535);
                    end
                    default:
                    begin
                        if (kind == 8)
                        begin
                            if ($urandom_range(0, 1) == 1)
                                dx = 0;
                            else
                                dy = 0;
                        end
                        // speed sized so the move takes a handful of ticks
                        reach = (dx < 0 ? -dx : dx);
                        if ((dy < 0 ? -dy : dy) > reach)
                            reach = (dy < 0 ? -dy : dy);
                        spd = reach / $urandom_range(1, 6);
                        if (spd < 1)
                            spd = 1;
                        spd = spd * 256 + $urandom_range(0, 255);
                        if (spd > 65535)
                            spd = 65535;
                    end
                endcase
                push_cmd(CMD_MOVE, dx, dy, spd);
                repeat ($urandom_range(1, 8))
                    push_cmd(CMD_TICK, $urandom, $urandom, $urandom);
            end
        end
    endtask

    // wait until every command is sent and every result is back, then settle
    task automatic wait_idle(input int settle);
        while (pending_cmds.size() != 0 || cmd_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (settle)
            @(posedge clk);
    endtask

    // driver: presents queued command transactions, random gap after each one
    always @(posedge clk)
    begin
        res_t want;
        int   gap;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                // accepted payload is the one still on the bus this edge
                predict_sprite_step(cmd_data, want);
                pending_results.push_back(want);
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                gap = send_burst ? 0 : $urandom_range(0, 3);
                if (gap == 0 && pending_cmds.size() != 0)
                    cmd_data <= pending_cmds.pop_front();
                else
                begin
                    cmd_valid <= 1'b0;
                    send_gap  <= gap;
                end
            end
            else if (!cmd_valid)
            begin
                if (send_gap != 0)
                    send_gap <= send_gap - 1;
                else if (pending_cmds.size() != 0)
                begin
                    cmd_data  <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                end
            end
        end
    end

    // monitor: checks each result transaction, then stalls the next one a random while
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_count));
                else
                begin
                    want = pending_results.pop_front();
                    check_field("pos_x", res_data.pos_x, want.pos_x);
                    check_field("pos_y", res_data.pos_y, want.pos_y);
                    check_field("facing", res_data.facing, want.facing);
                    check_field("frame", res_data.frame, want.frame);
                    check_field("moving", res_data.moving, want.moving);
                    check_field("finished", res_data.finished, want.finished);
                end
                result_count++;
                if ($urandom_range(0, 39) == 0)
                    take_burst = !take_burst;
                wait_left = take_burst ? 0 : $urandom_range(0, 3);
            end
            else if (res_valid && wait_left > 0)
                wait_left--;
            // stall is held through the wait for the result and then counted down
            res_stall <= (wait_left > 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned fc_plan[9];
        fc_plan = '{2, 16, 1, 0, 31, 17, 9, 3, 5};
        fc_plan[8] = $urandom_range(2, 16);

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle tick straight out of reset
        push_cmd(CMD_TICK, 0, 0, 0);
        // place at the coordinate extremes
        push_cmd(CMD_PLACE, 32767, -32768, 16'hffff);
        push_cmd(CMD_PLACE, -32768, 32767, 0);
        push_cmd(CMD_PLACE, 0, 0, 0);
        // zero move finishes at once
        push_cmd(CMD_MOVE, 0, 0, 16'h1234);
        // speed zero and just below one pixel jump the whole way
        push_cmd(CMD_MOVE, 100, -50, 0);
        push_cmd(CMD_TICK, 0, 0, 0);
        push_cmd(CMD_MOVE, -30, 40, 255);
        push_cmd(CMD_TICK, 0, 0, 0);
        // exactly one pixel per tick
        push_cmd(CMD_MOVE, 3, 4, 256);
        push_cmd(CMD_TICK, 0, 0, 0);
        push_cmd(CMD_TICK, 0, 0, 0);
        push_cmd(CMD_TICK, 0, 0, 0);
        // fastest speed overshoots and snaps
        push_cmd(CMD_MOVE, 3, -4, 65535);
        push_cmd(CMD_TICK, 0, 0, 0);
        // position saturation on a jump
        push_cmd(CMD_PLACE, 32000, -32000, 0);
        push_cmd(CMD_MOVE, 32767, -32768, 0);
        push_cmd(CMD_TICK, 0, 0, 0);
        // largest distances at full speed
        push_cmd(CMD_MOVE, -32768, 32767, 65535);
        push_cmd(CMD_TICK, 0, 0, 0);
        push_cmd(CMD_TICK, 0, 0, 0);
        // unused code with every argument bit set
        push_cmd(CMD_UNUSED, 16'hffff, 16'hffff, 16'hffff);
        // equal distances, y wins the facing tie
        push_cmd(CMD_MOVE, 7, 7, 16'h0380);
        push_cmd(CMD_TICK, 0, 0, 0);
        push_cmd(CMD_TICK, 0, 0, 0);

        gen_random_items(RANDOM_PER_PHASE);

        // one phase per frame_count setting, written only while the block is idle
        foreach (fc_plan[i])
        begin
            wait_idle(IDLE_GAP);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= fc_plan[i][FC_W-1:0];
            frame_limit  = fc_plan[i];
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            gen_random_items(RANDOM_PER_PHASE);
        end

        wait_idle(TAIL_CYCLES);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
